// ===== rtl/core/stt_pkg.sv =====
// Shared types, constants and character-class functions for the source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   // Width of the internal byte offset and lexeme length counters.
   localparam int OffsetBits = 16;
   // Width of the token start and length fields on the result port.
   localparam int OutBits    = 16;
   localparam int WideBits   = (OffsetBits > OutBits) ? OffsetBits : OutBits;

   localparam int KwCount    = 11;
   localparam int KwMaxLen   = 6;
   localparam int LetterBits = 8 * KwMaxLen;

   localparam int SlotCount  = 3;
   localparam int CountBits  = 2;

   typedef logic [OffsetBits-1:0] off_type;
   typedef logic [7:0]            char_type;
   typedef logic [5:0]            kind_type;
   typedef logic [LetterBits-1:0] letters_type;

   localparam off_type OffMax = '1;

   // Token kinds.
   localparam kind_type KindEof    = 6'd0;
   localparam kind_type KindError  = 6'd1;
   localparam kind_type KindIdent  = 6'd2;
   localparam kind_type KindInt    = 6'd3;
   localparam kind_type KindFloat  = 6'd4;
   localparam kind_type KindKwBase = 6'd5;
   localparam kind_type KindLparen = 6'd16;
   localparam kind_type KindRparen = 6'd17;
   localparam kind_type KindSemi   = 6'd18;
   localparam kind_type KindComma  = 6'd19;
   localparam kind_type KindLbrace = 6'd20;
   localparam kind_type KindRbrace = 6'd21;
   localparam kind_type KindPlus   = 6'd22;
   localparam kind_type KindMinus  = 6'd23;
   localparam kind_type KindStar   = 6'd24;
   localparam kind_type KindSlash  = 6'd25;
   localparam kind_type KindAssign = 6'd26;
   localparam kind_type KindLt     = 6'd28;
   localparam kind_type KindGt     = 6'd30;
   localparam kind_type KindBang   = 6'd32;
   localparam kind_type KindAndAnd = 6'd34;
   localparam kind_type KindOrOr   = 6'd35;

   // Keyword spellings, first character in the low byte, zero padded.
   localparam letters_type KwText [KwCount] = '{
      48'h0000_0072_6176,   // var
      48'h0000_0000_6E66,   // fn
      48'h0000_0074_6E69,   // int
      48'h0074_616F_6C66,   // float
      48'h0000_6C6F_6F62,   // bool
      48'h0000_6575_7274,   // true
      48'h0065_736C_6166,   // false
      48'h6E72_7574_6572,   // return
      48'h0000_0000_6669,   // if
      48'h0000_6573_6C65,   // else
      48'h0065_6C69_6877    // while
   };
   localparam logic [2:0] KwLen [KwCount] = '{
      3'd3, 3'd2, 3'd3, 3'd5, 3'd4, 3'd4, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5
   };

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_INT,
      MODE_FLOAT,
      MODE_ERR,
      MODE_OP
   } scan_mode_type;

   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_EQ,
      PEND_LT,
      PEND_GT,
      PEND_BANG,
      PEND_AMP,
      PEND_BAR
   } pend_type;

   typedef struct packed {
      kind_type           kind;
      logic [OutBits-1:0] start;
      logic [OutBits-1:0] length;
   } tok_type;

   typedef struct packed {
      logic    hit;
      tok_type tok;
   } tok_opt_type;

   // Up to three tokens caused by one input byte, in emission order.
   typedef struct packed {
      logic [CountBits-1:0]          count;
      tok_type [SlotCount-1:0]       slot;
   } bundle_type;

   function automatic logic blank_char(char_type c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
             c == 8'h0C || c == 8'h0B || c == 8'h00;
   endfunction

   function automatic logic is_opch(char_type c);
      return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
             c == "<" || c == ">" || c == "!" || c == "&" || c == "|";
   endfunction

   function automatic logic is_punct(char_type c);
      return c == "(" || c == ")" || c == ";" || c == "," || c == "{" || c == "}";
   endfunction

   function automatic logic is_sep(char_type c);
      return blank_char(c) || is_opch(c) || is_punct(c);
   endfunction

   function automatic logic digit_char(char_type c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic ident_head(char_type c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   // Kind of a byte that is a complete one-byte token on its own, else KindEof.
   function automatic kind_type direct_kind(char_type c);
      kind_type k;
      k = KindEof;
      unique case (c)
         "+":     k = KindPlus;
         "-":     k = KindMinus;
         "*":     k = KindStar;
         "/":     k = KindSlash;
         "(":     k = KindLparen;
         ")":     k = KindRparen;
         ";":     k = KindSemi;
         ",":     k = KindComma;
         "{":     k = KindLbrace;
         "}":     k = KindRbrace;
         default: k = KindEof;
      endcase
      return k;
   endfunction

   // Operator character that may be the first of a two-byte operator.
   function automatic pend_type pend_of(char_type c);
      pend_type p;
      p = PEND_NONE;
      unique case (c)
         "=":     p = PEND_EQ;
         "<":     p = PEND_LT;
         ">":     p = PEND_GT;
         "!":     p = PEND_BANG;
         "&":     p = PEND_AMP;
         "|":     p = PEND_BAR;
         default: p = PEND_NONE;
      endcase
      return p;
   endfunction

   function automatic kind_type single_kind(pend_type p);
      kind_type k;
      k = KindError;
      unique case (p)
         PEND_EQ:   k = KindAssign;
         PEND_LT:   k = KindLt;
         PEND_GT:   k = KindGt;
         PEND_BANG: k = KindBang;
         default:   k = KindError;
      endcase
      return k;
   endfunction

   function automatic off_type sat_inc(off_type v);
      return (v == OffMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [OutBits-1:0] clamp_out(off_type v);
      logic [WideBits-1:0] w;
      w = WideBits'(v);
      if (w > WideBits'({OutBits{1'b1}})) begin
         return {OutBits{1'b1}};
      end
      return OutBits'(w);
   endfunction

   function automatic tok_type make_tok(kind_type kind, off_type start, off_type length);
      tok_type t;
      t.kind   = kind;
      t.start  = clamp_out(start);
      t.length = clamp_out(length);
      return t;
   endfunction

   // Appends a token to a bundle; a full bundle drops further tokens.
   function automatic bundle_type push(bundle_type b, tok_type t);
      bundle_type r;
      r = b;
      if (b.count < CountBits'(SlotCount)) begin
         r.slot[b.count] = t;
         r.count         = b.count + 1'b1;
      end
      return r;
   endfunction

   function automatic kind_type ident_kind(off_type len, logic faulty, letters_type lt);
      kind_type k;
      k = KindIdent;
      if (faulty) begin
         k = KindError;
      end else if (len <= OffsetBits'(KwMaxLen)) begin
         // Bytes past the lexeme's length are zero, so a whole-word compare suffices.
         for (int i = 0; i < KwCount; i++) begin
            if (len[2:0] == KwLen[i] && lt == KwText[i]) begin
               k = KindKwBase + kind_type'(i);
            end
         end
      end
      return k;
   endfunction

   // Token that closing the open lexeme produces, if any.
   function automatic tok_opt_type close_token(scan_mode_type m, pend_type p, off_type ls,
                                               off_type ln, logic f, letters_type lt);
      tok_opt_type r;
      r.hit = 1'b1;
      r.tok = make_tok(KindError, ls, ln);
      unique case (m)
         MODE_IDENT: r.tok.kind = ident_kind(ln, f, lt);
         MODE_INT:   r.tok.kind = f ? KindError : KindInt;
         MODE_FLOAT: r.tok.kind = f ? KindError : KindFloat;
         MODE_ERR:   r.tok.kind = KindError;
         MODE_OP:    r.tok = make_tok(single_kind(p), ls, OffsetBits'(1));
         default:    r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stt_scan.sv =====
// Scanner state registers and the single-pass logic that turns one byte into its tokens.
`timescale 1ns / 1ps
`default_nettype none

module stt_scan (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire stt_pkg::char_type   text_byte,
   input  wire logic                end_of_text,
   output stt_pkg::bundle_type      bundle
);

   stt_pkg::scan_mode_type mode_ff,    mode_in;
   stt_pkg::pend_type      pend_ff,    pend_in;
   stt_pkg::off_type       start_ff,   start_in;
   stt_pkg::off_type       offset_ff,  offset_in;
   stt_pkg::off_type       len_ff,     len_in;
   stt_pkg::letters_type   letters_ff, letters_in;
   logic                   faulty_ff,  faulty_in;

   always_comb begin
      stt_pkg::bundle_type  b;
      stt_pkg::tok_opt_type ct;
      stt_pkg::kind_type    dk;
      stt_pkg::pend_type    np;
      logic                 do_close;
      logic                 do_start;

      b          = '0;
      ct         = '0;
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      letters_in = letters_ff;
      faulty_in  = faulty_ff;
      do_close   = 1'b0;
      do_start   = 1'b0;
      dk         = stt_pkg::direct_kind(text_byte);
      np         = stt_pkg::pend_of(text_byte);

      unique case (mode_ff)
         stt_pkg::MODE_IDENT: begin
            if (stt_pkg::is_sep(text_byte)) begin
               do_close = 1'b1;
               do_start = 1'b1;
            end else begin
               if (!stt_pkg::ident_head(text_byte) && !stt_pkg::digit_char(text_byte)) begin
                  faulty_in = 1'b1;
               end
               if (len_ff < stt_pkg::OffsetBits'(stt_pkg::KwMaxLen)) begin
                  letters_in[{len_ff[2:0], 3'b000} +: 8] =
                     letters_ff[{len_ff[2:0], 3'b000} +: 8] | text_byte;
               end
               len_in = stt_pkg::sat_inc(len_ff);
            end
         end
         stt_pkg::MODE_INT, stt_pkg::MODE_FLOAT: begin
            if (stt_pkg::is_sep(text_byte)) begin
               do_close = 1'b1;
               do_start = 1'b1;
            end else begin
               if (!stt_pkg::digit_char(text_byte)) begin
                  // One dot in a clean integer turns it into a float.
                  if (text_byte == "." && mode_ff == stt_pkg::MODE_INT && !faulty_ff) begin
                     mode_in = stt_pkg::MODE_FLOAT;
                  end else begin
                     faulty_in = 1'b1;
                  end
               end
               len_in = stt_pkg::sat_inc(len_ff);
            end
         end
         stt_pkg::MODE_ERR: begin
            if (stt_pkg::is_sep(text_byte)) begin
               do_close = 1'b1;
               do_start = 1'b1;
            end else begin
               len_in = stt_pkg::sat_inc(len_ff);
            end
         end
         stt_pkg::MODE_OP: begin
            if ((pend_ff == stt_pkg::PEND_EQ || pend_ff == stt_pkg::PEND_LT ||
                 pend_ff == stt_pkg::PEND_GT || pend_ff == stt_pkg::PEND_BANG) &&
                text_byte == "=") begin
               b = stt_pkg::push(b, stt_pkg::make_tok(stt_pkg::single_kind(pend_ff) + 1'b1,
                                                      start_ff, stt_pkg::OffsetBits'(2)));
               mode_in = stt_pkg::MODE_IDLE;
               pend_in = stt_pkg::PEND_NONE;
            end else if ((pend_ff == stt_pkg::PEND_AMP && text_byte == "&") ||
                         (pend_ff == stt_pkg::PEND_BAR && text_byte == "|")) begin
               b = stt_pkg::push(b, stt_pkg::make_tok(
                      (pend_ff == stt_pkg::PEND_AMP) ? stt_pkg::KindAndAnd : stt_pkg::KindOrOr,
                      start_ff, stt_pkg::OffsetBits'(2)));
               mode_in = stt_pkg::MODE_IDLE;
               pend_in = stt_pkg::PEND_NONE;
            end else if ((pend_ff == stt_pkg::PEND_AMP || pend_ff == stt_pkg::PEND_BAR) &&
                         !stt_pkg::is_sep(text_byte)) begin
               // A lone ampersand or bar glued to more text becomes an error span.
               mode_in = stt_pkg::MODE_ERR;
               pend_in = stt_pkg::PEND_NONE;
               len_in  = stt_pkg::sat_inc(len_ff);
            end else begin
               do_close = 1'b1;
               do_start = 1'b1;
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      if (do_close) begin
         ct = stt_pkg::close_token(mode_ff, pend_ff, start_ff, len_ff, faulty_ff, letters_ff);
         if (ct.hit) begin
            b = stt_pkg::push(b, ct.tok);
         end
         mode_in = stt_pkg::MODE_IDLE;
         pend_in = stt_pkg::PEND_NONE;
      end

      if (do_start) begin
         mode_in = stt_pkg::MODE_IDLE;
         pend_in = stt_pkg::PEND_NONE;
         if (!stt_pkg::blank_char(text_byte)) begin
            priority if (stt_pkg::ident_head(text_byte) || stt_pkg::digit_char(text_byte) ||
                         (dk == stt_pkg::KindEof && np != stt_pkg::PEND_NONE) ||
                         dk == stt_pkg::KindEof) begin
               // Opens a new lexeme at the current offset.
               start_in   = offset_ff;
               len_in     = stt_pkg::OffsetBits'(1);
               faulty_in  = 1'b0;
               letters_in = stt_pkg::LetterBits'(text_byte);
               priority if (stt_pkg::ident_head(text_byte)) begin
                  mode_in = stt_pkg::MODE_IDENT;
               end else if (stt_pkg::digit_char(text_byte)) begin
                  mode_in = stt_pkg::MODE_INT;
               end else if (np != stt_pkg::PEND_NONE) begin
                  mode_in = stt_pkg::MODE_OP;
                  pend_in = np;
               end else begin
                  mode_in = stt_pkg::MODE_ERR;
               end
            end else begin
               b = stt_pkg::push(b, stt_pkg::make_tok(dk, offset_ff, stt_pkg::OffsetBits'(1)));
            end
         end
      end

      offset_in = stt_pkg::sat_inc(offset_ff);

      if (end_of_text) begin
         ct = stt_pkg::close_token(mode_in, pend_in, start_in, len_in, faulty_in, letters_in);
         if (ct.hit) begin
            b = stt_pkg::push(b, ct.tok);
         end
         b = stt_pkg::push(b, stt_pkg::make_tok(stt_pkg::KindEof, offset_in, '0));
         mode_in    = stt_pkg::MODE_IDLE;
         pend_in    = stt_pkg::PEND_NONE;
         start_in   = '0;
         offset_in  = '0;
         len_in     = '0;
         letters_in = '0;
         faulty_in  = 1'b0;
      end

      bundle = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= stt_pkg::MODE_IDLE;
         pend_ff    <= stt_pkg::PEND_NONE;
         start_ff   <= '0;
         offset_ff  <= '0;
         len_ff     <= '0;
         letters_ff <= '0;
         faulty_ff  <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         pend_ff    <= pend_in;
         start_ff   <= start_in;
         offset_ff  <= offset_in;
         len_ff     <= len_in;
         letters_ff <= letters_in;
         faulty_ff  <= faulty_in;
      end
   end

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      mode_ff == stt_pkg::MODE_IDLE |-> pend_ff == stt_pkg::PEND_NONE)
      else $error("Pending operator held outside operator mode.");

   a_op_has_pend: assert property (@(posedge clock) disable iff (reset)
      mode_ff == stt_pkg::MODE_OP |-> pend_ff != stt_pkg::PEND_NONE)
      else $error("Operator mode without a pending operator.");

   a_eot_restarts: assert property (@(posedge clock) disable iff (reset)
      step && end_of_text |=> offset_ff == '0 && mode_ff == stt_pkg::MODE_IDLE)
      else $error("Scanner did not return to its start state after the last byte.");

   a_eot_tokens: assert property (@(posedge clock) disable iff (reset)
      step && end_of_text |-> bundle.count != '0)
      else $error("Last byte of a text produced no eof token.");

endmodule

`default_nettype wire

// ===== rtl/core/stt_tokq.sv =====
// Result register holding the tokens of one byte and handing them out one beat at a time.
`timescale 1ns / 1ps
`default_nettype none

module stt_tokq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire stt_pkg::bundle_type bundle,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output stt_pkg::tok_type         token,
   output logic                     last
);

   logic [stt_pkg::CountBits-1:0]           cnt_ff, cnt_in;
   logic [stt_pkg::CountBits-1:0]           rd_ff,  rd_in;
   stt_pkg::tok_type [stt_pkg::SlotCount-1:0] slot_ff;
   logic                                    pop;

   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (cnt_ff == '0) || (cnt_ff == stt_pkg::CountBits'(1) && rsp_ready);
   assign token     = slot_ff[rd_ff];
   assign last      = (cnt_ff == stt_pkg::CountBits'(1));

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (load) begin
         cnt_in = bundle.count;
         rd_in  = '0;
      end else if (pop) begin
         cnt_in = cnt_ff - 1'b1;
         rd_in  = rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("Token bundle loaded over undelivered tokens.");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rd_ff} + {1'b0, cnt_ff}) <= 3'(stt_pkg::SlotCount))
      else $error("Read index and remaining count run past the token slots.");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      pop && last && !load |=> !rsp_valid)
      else $error("Queue still valid after its last token was taken.");

endmodule

`default_nettype wire

// ===== rtl/core/source_text_tokenizer.sv =====
// Top level of the streaming source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes source text one byte per beat on the req_ channel, the
// last byte of a text flagged by req_end_of_text, and returns one token per
// lexeme on the rsp_ channel: its kind, its start offset and its length in
// bytes, both saturating. Whitespace and NUL are skipped; identifiers are
// matched against the eleven keywords; malformed spans run to the next
// separator and come out as error tokens. After the last byte of a text an
// eof token follows and the scanner starts over at offset zero. rsp_run_last
// marks the final token caused by one input byte. A byte passes through an
// input register, is scanned combinationally into a bundle of up to three
// tokens, and the bundle sits in a result register that hands out one token
// per beat, so the first token of a byte is offered on the rsp_ channel once
// the byte has passed the input register and been loaded into the result
// register. The input side takes one byte every cycle as long as each
// byte yields at most one token; a byte that yields two or three tokens
// occupies the result register until all of them are taken, and the input
// register absorbs one further byte in that time before req_ready drops.
// Back pressure on rsp_ready stalls the chain in the same way.
module source_text_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_length,
   output logic             rsp_run_last
);

   // Input register: one byte waiting to be scanned.
   logic                in_vld_ff, in_vld_in;
   stt_pkg::char_type   byte_ff;
   logic                eot_ff;

   stt_pkg::bundle_type bundle;
   stt_pkg::tok_type    token;
   logic                q_free;
   logic                advance;
   logic                load;

   // The held byte is scanned once the result register can take its tokens;
   // a byte that yields no token never needs the result register.
   assign advance   = in_vld_ff && ((bundle.count == '0) || q_free);
   assign load      = advance && (bundle.count != '0);
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_text_byte;
         eot_ff  <= req_end_of_text;
      end
   end

   stt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_byte   (byte_ff),
      .end_of_text (eot_ff),
      .bundle      (bundle)
   );

   stt_tokq u_tokq (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle    (bundle),
      .free      (q_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .token     (token),
      .last      (rsp_run_last)
   );

   assign rsp_token_kind   = token.kind;
   assign rsp_token_start  = token.start;
   assign rsp_token_length = token.length;

endmodule

`default_nettype wire
